/* hw/rtl/seconds_to_calendar_date_top_macros.svh */
// Assertion macros for the seconds-to-date block.
// Included by the checker; expects clk and rst in scope.
`ifndef SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH
`define SECONDS_TO_CALENDAR_DATE_TOP_MACROS_SVH

// Checked only outside reset.
`define S2CD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define S2CD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/s2cd_pkg.sv */
// Shared types, command codes and constants for the seconds-to-date block.
// No dependencies.
`timescale 1ns / 1ps

package s2cd_pkg;

  localparam int IN_W  = 32;
  localparam int OUT_W = 48;

  // datapath command codes
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL60    = 4'd2;
  localparam logic [3:0] OP_DIV_SEC  = 4'd3;
  localparam logic [3:0] OP_DIV_MIN  = 4'd4;
  localparam logic [3:0] OP_MUL24    = 4'd5;
  localparam logic [3:0] OP_DIV_HR   = 4'd6;
  localparam logic [3:0] OP_MUL7     = 4'd7;
  localparam logic [3:0] OP_DIV_WDAY = 4'd8;
  localparam logic [3:0] OP_YEAR     = 4'd9;
  localparam logic [3:0] OP_MONTH    = 4'd10;
  localparam logic [3:0] OP_OUT      = 4'd11;

  // reciprocals: x/15 = (x*M15)>>35, x/3 = (x*M3)>>33, n/7 = (n*M7)>>19 for n < 2^16
  localparam logic [31:0] RECIP_15 = 32'h8888_8889;
  localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_7  = 32'd74899;

  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  // only multiple of 100 in 1970..2106 that is not a leap year
  localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
  localparam logic [3:0]  LAST_MONTH       = 4'd12;
  localparam logic [31:0] EPOCH_WEEKDAY    = 32'd3;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic year_fit;
    logic month_fit;
  } status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/seconds_to_calendar_date_top.sv */
// Seconds since 1970-01-01 to calendar date and time of day.
// The year/month loop does one subtraction per cycle: one per whole year since 1970, then
// one per whole month into the year. The output register lets the next word in while a
// result waits. Synchronous active-high rst clears the controller and tvalid.
`timescale 1ns / 1ps

module seconds_to_calendar_date_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [19:17] day_of_week, [31:20] calendar_year, [35:32] month_of_year,
  // [40:36] day_of_month, [47:41] zero
  output logic [47:0] m_axis_tdata
);

  s2cd_pkg::cmd_t    cmd;
  s2cd_pkg::status_t status;

  s2cd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  s2cd_datapath u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .in_seconds (s_axis_tdata),
    .status     (status),
    .out_word   (m_axis_tdata)
  );

endmodule

/* hw/rtl/s2cd_datapath.sv */
// Datapath: shared reciprocal multiplier, time-of-day and weekday split, year and month subtraction.
// Depends on s2cd_pkg; driven by s2cd_ctrl commands.
`timescale 1ns / 1ps

module s2cd_datapath (
  input  logic                       clk,
  input  s2cd_pkg::cmd_t             cmd,
  input  logic [s2cd_pkg::IN_W-1:0]  in_seconds,
  output s2cd_pkg::status_t          status,
  output logic [s2cd_pkg::OUT_W-1:0] out_word
);

  logic [31:0] work;
  logic [63:0] prod;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hr;
  logic [2:0]  wday;
  logic [11:0] year;
  logic [3:0]  month;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [15:0] days;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] q60;
  logic [31:0] q24;
  logic [31:0] q7;
  logic [31:0] wbase;
  logic [5:0]  rem60;
  logic [4:0]  rem24;
  logic [2:0]  rem7;
  logic [4:0]  mday;

  assign leap  = (year[1:0] == 2'b00) && (year != s2cd_pkg::NON_LEAP_CENTURY);
  assign ylen  = leap ? 9'd366 : 9'd365;
  assign mlen  = s2cd_pkg::month_len(month, leap);
  assign days  = work[15:0];
  assign mday  = days[4:0] + 5'd1;

  assign status.year_fit  = days >= {7'b0, ylen};
  assign status.month_fit = (days >= {11'b0, mlen}) && (month < s2cd_pkg::LAST_MONTH);

  assign wbase = work + s2cd_pkg::EPOCH_WEEKDAY;
  assign q60   = {3'b0, prod[63:35]};
  assign q24   = {1'b0, prod[63:33]};
  assign q7    = {19'b0, prod[31:19]};
  assign rem60 = 6'(work - q60 * 32'd60);
  assign rem24 = 5'(work - q24 * 32'd24);
  assign rem7  = 3'(wbase - q7 * 32'd7);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      s2cd_pkg::OP_MUL60: begin
        mul_a = {2'b0, work[31:2]};
        mul_b = s2cd_pkg::RECIP_15;
      end
      s2cd_pkg::OP_MUL24: begin
        mul_a = {3'b0, work[31:3]};
        mul_b = s2cd_pkg::RECIP_3;
      end
      s2cd_pkg::OP_MUL7: begin
        mul_a = wbase;
        mul_b = s2cd_pkg::RECIP_7;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      s2cd_pkg::OP_LOAD: begin
        work  <= in_seconds;
        year  <= s2cd_pkg::EPOCH_YEAR;
        month <= 4'd1;
      end
      s2cd_pkg::OP_MUL60, s2cd_pkg::OP_MUL24, s2cd_pkg::OP_MUL7: begin
        prod <= 64'(mul_a) * 64'(mul_b);
      end
      s2cd_pkg::OP_DIV_SEC: begin
        sec  <= rem60;
        work <= q60;
      end
      s2cd_pkg::OP_DIV_MIN: begin
        min  <= rem60;
        work <= q60;
      end
      s2cd_pkg::OP_DIV_HR: begin
        hr   <= rem24;
        work <= q24;
      end
      s2cd_pkg::OP_DIV_WDAY: begin
        wday <= rem7 + 3'd1;
      end
      s2cd_pkg::OP_YEAR: begin
        work <= work - {23'b0, ylen};
        year <= year + 12'd1;
      end
      s2cd_pkg::OP_MONTH: begin
        work  <= work - {27'b0, mlen};
        month <= month + 4'd1;
      end
      s2cd_pkg::OP_OUT: begin
        out_word <= {7'b0, mday, month, year, wday, hr, min, sec};
      end
      default: begin
      end
    endcase
  end

endmodule

/* hw/rtl/s2cd_ctrl.sv */
// Controller: sequences the split, year and month steps and owns the handshakes.
// Depends on s2cd_pkg; drives s2cd_datapath.
`timescale 1ns / 1ps

module s2cd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  s2cd_pkg::status_t status,
  output s2cd_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MUL_SEC  = 4'd1;
  localparam logic [3:0] ST_DIV_SEC  = 4'd2;
  localparam logic [3:0] ST_MUL_MIN  = 4'd3;
  localparam logic [3:0] ST_DIV_MIN  = 4'd4;
  localparam logic [3:0] ST_MUL_HR   = 4'd5;
  localparam logic [3:0] ST_DIV_HR   = 4'd6;
  localparam logic [3:0] ST_MUL_WDAY = 4'd7;
  localparam logic [3:0] ST_DIV_WDAY = 4'd8;
  localparam logic [3:0] ST_YEAR     = 4'd9;
  localparam logic [3:0] ST_MONTH    = 4'd10;
  localparam logic [3:0] ST_DONE     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = s2cd_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = s2cd_pkg::OP_LOAD;
          state_next = ST_MUL_SEC;
        end
      end
      ST_MUL_SEC: begin
        cmd.op     = s2cd_pkg::OP_MUL60;
        state_next = ST_DIV_SEC;
      end
      ST_DIV_SEC: begin
        cmd.op     = s2cd_pkg::OP_DIV_SEC;
        state_next = ST_MUL_MIN;
      end
      ST_MUL_MIN: begin
        cmd.op     = s2cd_pkg::OP_MUL60;
        state_next = ST_DIV_MIN;
      end
      ST_DIV_MIN: begin
        cmd.op     = s2cd_pkg::OP_DIV_MIN;
        state_next = ST_MUL_HR;
      end
      ST_MUL_HR: begin
        cmd.op     = s2cd_pkg::OP_MUL24;
        state_next = ST_DIV_HR;
      end
      ST_DIV_HR: begin
        cmd.op     = s2cd_pkg::OP_DIV_HR;
        state_next = ST_MUL_WDAY;
      end
      ST_MUL_WDAY: begin
        cmd.op     = s2cd_pkg::OP_MUL7;
        state_next = ST_DIV_WDAY;
      end
      ST_DIV_WDAY: begin
        cmd.op     = s2cd_pkg::OP_DIV_WDAY;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (status.year_fit) begin
          cmd.op = s2cd_pkg::OP_YEAR;
        end else begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status.month_fit) begin
          cmd.op = s2cd_pkg::OP_MONTH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = s2cd_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.op == s2cd_pkg::OP_OUT) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/s2cd_checker.sv */
// Port-level checker for seconds_to_calendar_date_top, bound to the top level.
// Depends on seconds_to_calendar_date_top_macros.svh.
`timescale 1ns / 1ps
`include "seconds_to_calendar_date_top_macros.svh"

module s2cd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  `S2CD_ASSERT_ALWAYS(a_reset_state, rst |=> (!m_axis_tvalid && s_axis_tready), "bad state after reset")

  `S2CD_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "output word dropped or changed while stalled")

  `S2CD_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while a word is in work")

  `S2CD_ASSERT(a_field_range, m_axis_tvalid |-> (m_axis_tdata[47:41] == 7'd0 && m_axis_tdata[5:0] < 6'd60 && m_axis_tdata[11:6] < 6'd60 && m_axis_tdata[16:12] < 5'd24 && m_axis_tdata[19:17] != 3'd0 && m_axis_tdata[35:32] != 4'd0 && m_axis_tdata[35:32] < 4'd13 && m_axis_tdata[40:36] != 5'd0), "output field out of range")

endmodule

bind seconds_to_calendar_date_top s2cd_checker u_s2cd_checker (.*);

/* dv/tb_seconds_to_calendar_date_top.sv */
// Testbench for seconds_to_calendar_date_top: drives epoch-second words with random bursts and
// output stalls, predicts each calendar date in place and checks every result word in order.
// Depends only on the RTL of the block.
`timescale 1ns / 1ps

module tb_seconds_to_calendar_date_top;

  // result word, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [11:0] calendar_year;
    logic [2:0]  day_of_week;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } calendar_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  localparam int unsigned FIRST_YEAR   = 1970;
  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned LAST_DAY_NO  = 49709;  // last whole day that fits in 32 bits

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  calendar_t   pending_dates[$];
  int          date_errors = 0;
  int          burst_left = 0;
  int          hold_cycles = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_mode_left = 0;

  seconds_to_calendar_date_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic calendar_t predict_calendar(input logic [31:0] secs);
    calendar_t   d;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    d = '0;
    days = secs;
    d.second_of_minute = 6'(days % 60);
    days = days / 60;
    d.minute_of_hour = 6'(days % 60);
    days = days / 60;
    d.hour_of_day = 5'(days % 24);
    days = days / 24;
    // day zero was a Thursday
    d.day_of_week = 3'((days + 3) % 7 + 1);
    yr = FIRST_YEAR;
    len = is_leap(yr) ? 366 : 365;
    while (days >= len) begin
      days -= len;
      yr++;
      len = is_leap(yr) ? 366 : 365;
    end
    mon = 1;
    len = 31;
    while (days >= len && mon < 12) begin
      days -= len;
      mon++;
      case (mon)
        4, 6, 9, 11: len = 30;
        2:           len = is_leap(yr) ? 29 : 28;
        default:     len = 31;
      endcase
    end
    d.calendar_year = 12'(yr);
    d.month_of_year = 4'(mon);
    d.day_of_month  = 5'(days + 1);
    return d;
  endfunction

  task automatic send_epoch_seconds(input logic [31:0] secs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= secs;
    do @(posedge clk); while (!s_axis_tready);
    pending_dates.push_back(predict_calendar(secs));
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_for_dates();
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_dates();
    logic [31:0] corners [22] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
      32'd94694399,                 // Dec 31 of the first leap year
      32'd946684799, 32'd951782400, 32'd951868799, 32'd951868800,
      32'd978307199,                // Dec 31 of 2000, last day of a leap year
      32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'd4107542399, 32'd4107542400, // 2100 is not a leap year
      32'd4291747199, 32'd4291747200,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    foreach (corners[i]) send_epoch_seconds(corners[i]);
    stop_sending();
  endtask

  task automatic test_random_seconds();
    repeat (700) send_epoch_seconds($urandom);
    stop_sending();
  endtask

  // midnights, one second either side, and random times on random days
  task automatic test_day_edges();
    longint unsigned secs;
    int unsigned     day_no;
    int unsigned     off;
    repeat (450) begin
      day_no = $urandom_range(0, LAST_DAY_NO);
      case ($urandom_range(0, 4))
        0:       off = 0;
        1:       off = 1;
        2:       off = SECS_PER_DAY - 2;
        3:       off = SECS_PER_DAY - 1;
        default: off = $urandom_range(0, SECS_PER_DAY - 1);
      endcase
      secs = longint'(day_no) * SECS_PER_DAY + off;
      send_epoch_seconds(secs[31:0]);
    end
    stop_sending();
  endtask

  // receiver blocks for a long stretch while short conversions pile up
  task automatic test_output_hold();
    wait_for_dates();
    hold_cycles = 600;
    repeat (16) send_epoch_seconds($urandom_range(0, 40_000_000));
    stop_sending();
    wait_for_dates();
  endtask

  task automatic test_paused_sender();
    repeat (8) begin
      repeat (15) send_epoch_seconds($urandom);
      stop_sending();
      wait_for_dates();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 2));
        ready_mode_left <= $urandom_range(16, 300);
      end else begin
        ready_mode_left <= ready_mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        default:      m_axis_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    calendar_t got;
    calendar_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_dates.size() == 0) begin
        date_errors++;
        if (date_errors <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          date_errors++;
          if (date_errors <= 10)
            $display("date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d pad %h,",
                     want.calendar_year, want.month_of_year, want.day_of_month,
                     want.hour_of_day, want.minute_of_hour, want.second_of_minute,
                     want.day_of_week, want.pad,
                     " got %0d-%0d-%0d %0d:%0d:%0d wd %0d pad %h",
                     got.calendar_year, got.month_of_year, got.day_of_month,
                     got.hour_of_day, got.minute_of_hour, got.second_of_minute,
                     got.day_of_week, got.pad);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_dates();
    test_random_seconds();
    test_day_edges();
    test_output_hold();
    test_paused_sender();
    wait_for_dates();
    repeat (200) @(posedge clk);
    if (date_errors == 0 && pending_dates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #24_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
